// ===== rtl/imma_pkg.sv =====
// Shared types and constants for the integer matrix multiply-accumulate block.
// Holds command codes, sequencer states, register indexes and port widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imma_pkg;

	localparam int CMD_W      = 3;
	localparam int POS_W      = 4;
	localparam int VAL_W      = 32;
	localparam int REG_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 1;

	localparam logic [REG_W-1:0] DIM_RESET = 5'd16;

	typedef enum logic [CMD_W-1:0] {
		CMD_WR_A = 3'd0,
		CMD_WR_B = 3'd1,
		CMD_MAC  = 3'd2,
		CMD_MUL  = 3'd3,
		CMD_CLR  = 3'd4,
		CMD_RD   = 3'd5
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS  = 2'd0,
		REG_INNER = 2'd1,
		REG_COLS  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_WB,
		ST_FIN,
		ST_RD,
		ST_RD_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/imma_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module imma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/int_matrix_multiply_accumulate.sv =====
// Integer matrix multiply-accumulate: A, B and C stores with a shared MAC sequencer.
// Depends on imma_pkg and imma_ram.
`timescale 1ns / 1ps
`default_nettype none

// Loads of A and B elements (tuser command 0 or 1) are taken one per cycle while
// the block is idle and give no result. A read of C passes through the RD and
// RD_OUT states and then loads its result word. A compute (command 2 accumulates,
// 3 overwrites) runs one shared 32x32 multiplier and adder over every element:
// for each C element it makes one memory read of A and B per cycle, then lets the
// multiplier and adder drain and writes C back; a compute is followed by a
// completion word. Dimensions above MAX_DIM are used as MAX_DIM. A clear
// sweeps all 4**ceil(log2(MAX_DIM)) C entries one entry a cycle (256 at
// MAX_DIM 16), then gives a completion word; the same sweep runs once after
// reset, during which no word is accepted. Configuration writes are taken at any
// time but must only be made while the block is idle.
module int_matrix_multiply_accumulate #(
	parameter int MAX_DIM = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_we,
	input  wire logic [imma_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [imma_pkg::REG_W-1:0]          cfg_data,
	// input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [imma_pkg::IN_DATA_W-1:0]      s_tdata,  // row[3:0], col[7:4], value[39:8]
	input  wire logic [imma_pkg::IN_USER_W-1:0]      s_tuser,  // cmd[2:0]
	// output stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [imma_pkg::OUT_DATA_W-1:0]     m_tdata,  // read_value[31:0]
	output logic      [imma_pkg::OUT_USER_W-1:0]     m_tuser   // done_res[0]
);

	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int POS_W  = imma_pkg::POS_W;
	localparam int VAL_W  = imma_pkg::VAL_W;

	imma_pkg::state_t state_q, state_d;

	// configuration registers
	logic [imma_pkg::REG_W-1:0] rows_q, inner_q, cols_q;
	logic [DIM_W-1:0]           n_eff, l_eff, m_eff;

	// input word fields
	imma_pkg::cmd_t       in_cmd;
	logic [POS_W-1:0]     in_row, in_col;
	logic [VAL_W-1:0]     in_value;
	logic [IDX_W+POS_W-1:0] in_row_x, in_col_x;
	logic                 in_ok;
	logic                 accept;

	// sequencer registers
	logic [IDX_W-1:0]     i_q, j_q;
	logic [DIM_W-1:0]     k_q;
	logic [ADDR_W-1:0]    sweep_q;
	logic                 acc_mode_q;
	logic                 clr_pend_q;
	logic [IDX_W-1:0]     rd_row_q, rd_col_q;
	logic                 rd_ok_q;
	logic [VAL_W-1:0]     sum_q;

	// MAC pipeline
	logic                 rd_v_s1;
	logic                 mul_v_s2;
	logic [VAL_W-1:0]     prod_s2;

	// output register
	logic                 out_v_q;
	logic [VAL_W-1:0]     out_data_q;
	logic                 out_done_q;
	logic                 out_free;

	// control strobes
	logic start_cmp, start_clr, start_rd;
	logic issue, wb, sweep_en, out_load, out_done;
	logic i_last, j_last;

	// memory ports
	logic              a_we, b_we, c_we;
	logic [ADDR_W-1:0] ab_waddr, a_raddr, b_raddr, c_waddr, c_raddr;
	logic [VAL_W-1:0]  a_rdata, b_rdata, c_rdata, c_wdata;

	assign in_cmd   = imma_pkg::cmd_t'(s_tuser);
	assign in_row   = s_tdata[3:0];
	assign in_col   = s_tdata[7:4];
	assign in_value = s_tdata[39:8];
	assign in_row_x = {{IDX_W{1'b0}}, in_row};
	assign in_col_x = {{IDX_W{1'b0}}, in_col};
	assign in_ok    = ({28'd0, in_row} < 32'(MAX_DIM)) && ({28'd0, in_col} < 32'(MAX_DIM));
	assign ab_waddr = {in_row_x[IDX_W-1:0], in_col_x[IDX_W-1:0]};

	// saturate dimensions at MAX_DIM
	assign n_eff = (32'(rows_q)  > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(rows_q);
	assign l_eff = (32'(inner_q) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(inner_q);
	assign m_eff = (32'(cols_q)  > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cols_q);

	assign i_last   = (DIM_W'(i_q) + DIM_W'(1)) == n_eff;
	assign j_last   = (DIM_W'(j_q) + DIM_W'(1)) == m_eff;
	assign s_tready = (state_q == imma_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_v_q || m_tready;

	assign a_raddr = {i_q, k_q[IDX_W-1:0]};
	assign b_raddr = {k_q[IDX_W-1:0], j_q};
	assign c_raddr = ((state_q == imma_pkg::ST_RD) || (state_q == imma_pkg::ST_RD_OUT)) ?
		{rd_row_q, rd_col_q} : {i_q, j_q};

	always_comb begin
		state_d   = state_q;
		start_cmp = 1'b0;
		start_clr = 1'b0;
		start_rd  = 1'b0;
		issue     = 1'b0;
		wb        = 1'b0;
		sweep_en  = 1'b0;
		out_load  = 1'b0;
		out_done  = 1'b0;
		a_we      = 1'b0;
		b_we      = 1'b0;
		c_we      = 1'b0;
		c_waddr   = {i_q, j_q};
		c_wdata   = acc_mode_q ? (c_rdata + sum_q) : sum_q;
		unique case (state_q)
			imma_pkg::ST_SWEEP: begin
				sweep_en = 1'b1;
				c_we     = 1'b1;
				c_waddr  = sweep_q;
				c_wdata  = '0;
				if (sweep_q == {ADDR_W{1'b1}}) begin
					state_d = clr_pend_q ? imma_pkg::ST_FIN : imma_pkg::ST_IDLE;
				end
			end
			imma_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						imma_pkg::CMD_WR_A: a_we = in_ok;
						imma_pkg::CMD_WR_B: b_we = in_ok;
						imma_pkg::CMD_MAC, imma_pkg::CMD_MUL: begin
							start_cmp = 1'b1;
							if ((n_eff == '0) || (m_eff == '0)) begin
								state_d = imma_pkg::ST_FIN;
							end else begin
								state_d = imma_pkg::ST_MAC;
							end
						end
						imma_pkg::CMD_CLR: begin
							start_clr = 1'b1;
							state_d   = imma_pkg::ST_SWEEP;
						end
						imma_pkg::CMD_RD: begin
							start_rd = 1'b1;
							state_d  = imma_pkg::ST_RD;
						end
						default: ;
					endcase
				end
			end
			imma_pkg::ST_MAC: begin
				if (k_q < l_eff) begin
					issue = 1'b1;
				end else begin
					state_d = imma_pkg::ST_DRAIN;
				end
			end
			imma_pkg::ST_DRAIN: begin
				if (!rd_v_s1 && !mul_v_s2) begin
					state_d = imma_pkg::ST_WB;
				end
			end
			imma_pkg::ST_WB: begin
				wb   = 1'b1;
				c_we = 1'b1;
				state_d = (i_last && j_last) ? imma_pkg::ST_FIN : imma_pkg::ST_MAC;
			end
			imma_pkg::ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					out_done = 1'b1;
					state_d  = imma_pkg::ST_IDLE;
				end
			end
			imma_pkg::ST_RD: begin
				state_d = imma_pkg::ST_RD_OUT;
			end
			imma_pkg::ST_RD_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = imma_pkg::ST_IDLE;
				end
			end
			default: state_d = imma_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imma_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= imma_pkg::DIM_RESET;
			inner_q <= imma_pkg::DIM_RESET;
			cols_q  <= imma_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				imma_pkg::REG_ROWS:  rows_q  <= cfg_data;
				imma_pkg::REG_INNER: inner_q <= cfg_data;
				imma_pkg::REG_COLS:  cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			sweep_q    <= '0;
			acc_mode_q <= 1'b0;
			clr_pend_q <= 1'b0;
			rd_v_s1    <= 1'b0;
			mul_v_s2   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			rd_v_s1  <= issue;
			mul_v_s2 <= rd_v_s1;
			if (start_cmp) begin
				i_q        <= '0;
				j_q        <= '0;
				k_q        <= '0;
				acc_mode_q <= (in_cmd == imma_pkg::CMD_MAC);
			end
			if (issue) begin
				k_q <= k_q + DIM_W'(1);
			end
			if (wb) begin
				k_q <= '0;
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
			if (start_clr) begin
				sweep_q    <= '0;
				clr_pend_q <= 1'b1;
			end else if (sweep_en) begin
				sweep_q <= sweep_q + ADDR_W'(1);
			end
			if (out_done) begin
				clr_pend_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start_rd) begin
			rd_row_q <= in_row_x[IDX_W-1:0];
			rd_col_q <= in_col_x[IDX_W-1:0];
			rd_ok_q  <= in_ok;
		end
		if (rd_v_s1) begin
			prod_s2 <= a_rdata * b_rdata;
		end
		if (start_cmp || wb) begin
			sum_q <= '0;
		end else if (mul_v_s2) begin
			sum_q <= sum_q + prod_s2;
		end
		if (out_load) begin
			out_done_q <= out_done;
			out_data_q <= (out_done || !rd_ok_q) ? '0 : c_rdata;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_done_q;

	imma_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (ab_waddr),
		.wdata (in_value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	imma_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (ab_waddr),
		.wdata (in_value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	imma_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_c_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

endmodule

`default_nettype wire

// ===== dv/tb_int_matrix_multiply_accumulate.sv =====
`timescale 1ns / 1ps
// Self-checking bench for int_matrix_multiply_accumulate: a directed table, then phased
// random traffic over many dimension settings, each output word checked by model or table.
// Depends on imma_pkg and the block's RTL.
module tb_int_matrix_multiply_accumulate;
	import imma_pkg::*;

	localparam int DIM              = 16;
	localparam int SETTLE_CYCLES    = 16;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int TARGET_ITEMS     = 1625;
	localparam int QUIET_FROM       = 1400;
	localparam int DIR_N            = 26;
	localparam longint RUN_LIMIT_NS = 1500000;

	localparam logic [CMD_W-1:0]     CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0]     CMD_SPARE_7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
	localparam logic                 CHECK_TYPED = 1'b1;
	localparam logic                 CHECK_MODEL = 1'b0;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic             done_res;
	} out_word_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [VAL_W-1:0] value;
		logic             typed;
		logic [VAL_W-1:0] t_value;
		logic             t_done;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [REG_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	// bench copy of the stores and registers
	logic [VAL_W-1:0] a_mem [DIM*DIM];
	logic [VAL_W-1:0] b_mem [DIM*DIM];
	logic [VAL_W-1:0] c_mem [DIM*DIM];
	bit               a_loaded [DIM*DIM];
	bit               b_loaded [DIM*DIM];
	logic [REG_W-1:0] dim_rows, dim_inner, dim_cols;

	out_word_t words_due [$];
	int        mismatches;
	int        items_sent;
	bit        gap_on, stall_on, long_hold_req;

	dir_row_t dir_tab [DIR_N] = '{
		'{CMD_RD,    4'd0,  4'd0,  32'h0000_0000, CHECK_TYPED, 32'h0, 1'b0},
		'{CMD_RD,    4'd15, 4'd15, 32'hFFFF_FFFF, CHECK_TYPED, 32'h0, 1'b0},
		'{CMD_CLR,   4'd0,  4'd0,  32'h0000_0000, CHECK_TYPED, 32'h0, 1'b1},
		'{CMD_WR_A,  4'd0,  4'd0,  32'h7FFF_FFFF, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_WR_A,  4'd0,  4'd1,  32'h8000_0000, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_WR_A,  4'd1,  4'd0,  32'hFFFF_FFFF, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_WR_A,  4'd1,  4'd1,  32'h0000_0001, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_WR_B,  4'd0,  4'd0,  32'h7FFF_FFFF, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_WR_B,  4'd0,  4'd1,  32'hFFFF_FFFF, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_WR_B,  4'd1,  4'd0,  32'h8000_0000, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_WR_B,  4'd1,  4'd1,  32'h0000_0000, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_MUL,   4'd15, 4'd15, 32'hFFFF_FFFF, CHECK_TYPED, 32'h0, 1'b1},
		'{CMD_RD,    4'd0,  4'd0,  32'h0000_0000, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_RD,    4'd0,  4'd1,  32'h0000_0000, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_RD,    4'd1,  4'd0,  32'h0000_0000, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_RD,    4'd1,  4'd1,  32'h0000_0000, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_MAC,   4'd0,  4'd0,  32'h0000_0000, CHECK_TYPED, 32'h0, 1'b1},
		'{CMD_RD,    4'd0,  4'd0,  32'h0000_0000, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_RD,    4'd1,  4'd1,  32'h0000_0000, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_SPARE_6, 4'd3, 4'd4, 32'hDEAD_BEEF, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_SPARE_7, 4'd15, 4'd15, 32'hFFFF_FFFF, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_WR_A,  4'd15, 4'd15, 32'h1234_5678, CHECK_MODEL, 32'h0, 1'b0},
		'{CMD_WR_B,  4'd15, 4'd15, 32'h8765_4321, CHECK_MODEL, 32'h0, 1'b0},
		// outside the dimensions in use, so never touched by a compute
		'{CMD_RD,    4'd15, 4'd15, 32'h0000_0000, CHECK_TYPED, 32'h0, 1'b0},
		'{CMD_CLR,   4'd7,  4'd9,  32'h5555_AAAA, CHECK_TYPED, 32'h0, 1'b1},
		'{CMD_RD,    4'd0,  4'd0,  32'h0000_0000, CHECK_TYPED, 32'h0, 1'b0}
	};

	int_matrix_multiply_accumulate #(
		.MAX_DIM(DIM)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("tb_int_matrix_multiply_accumulate failed");
		$finish;
	end

	function automatic int unsigned eff_dim(input logic [REG_W-1:0] d);
		return (d > DIM) ? DIM : int'(d);
	endfunction

	function automatic void multiply_into_c(input bit accumulate);
		int unsigned n, l, m, i, j, k;
		logic [VAL_W-1:0] sum;
		n = eff_dim(dim_rows);
		l = eff_dim(dim_inner);
		m = eff_dim(dim_cols);
		for (i = 0; i < n; i++) begin
			for (j = 0; j < m; j++) begin
				sum = '0;
				for (k = 0; k < l; k++)
					sum = sum + a_mem[i*DIM + k] * b_mem[k*DIM + j];
				c_mem[i*DIM + j] = accumulate ? c_mem[i*DIM + j] + sum : sum;
			end
		end
	endfunction

	// 4-bit row and column can never reach past DIM, so every address is in range
	function automatic void apply_command(input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] row, input logic [POS_W-1:0] col,
			input logic [VAL_W-1:0] value, output bit gives, output out_word_t w);
		int unsigned idx, e;
		idx = row*DIM + col;
		gives = 1'b0;
		w = '0;
		case (cmd)
			CMD_WR_A: begin
				a_mem[idx] = value;
				a_loaded[idx] = 1'b1;
			end
			CMD_WR_B: begin
				b_mem[idx] = value;
				b_loaded[idx] = 1'b1;
			end
			CMD_MAC, CMD_MUL: begin
				multiply_into_c(cmd == CMD_MAC);
				gives = 1'b1;
				w.done_res = 1'b1;
			end
			CMD_CLR: begin
				for (e = 0; e < DIM*DIM; e++)
					c_mem[e] = '0;
				gives = 1'b1;
				w.done_res = 1'b1;
			end
			CMD_RD: begin
				gives = 1'b1;
				w.read_value = c_mem[idx];
			end
			default: ;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '1;
			3: return '0;
			4, 5, 6: return 32'(int'($urandom_range(0, 16)) - 8);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] row,
			input logic [POS_W-1:0] col, input logic [VAL_W-1:0] value,
			input logic typed, input out_word_t typed_word);
		bit gives;
		out_word_t w;
		if (gap_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {value, col, row};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		apply_command(cmd, row, col, value, gives, w);
		if (gives)
			words_due.push_back(typed ? typed_word : w);
		if (cmd <= CMD_RD)
			items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ROWS:  dim_rows  = data;
			REG_INNER: dim_inner = data;
			REG_COLS:  dim_cols  = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drop valid, wait for every owed word, then let trailing loads finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (words_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// a compute must never read an A or B entry that was never loaded
	task automatic load_missing_operands();
		int unsigned n, l, m, i, j;
		n = eff_dim(dim_rows);
		l = eff_dim(dim_inner);
		m = eff_dim(dim_cols);
		for (i = 0; i < n; i++)
			for (j = 0; j < l; j++)
				if (!a_loaded[i*DIM + j])
					send_item(CMD_WR_A, POS_W'(i), POS_W'(j), rand_value(), CHECK_MODEL, '0);
		for (i = 0; i < l; i++)
			for (j = 0; j < m; j++)
				if (!b_loaded[i*DIM + j])
					send_item(CMD_WR_B, POS_W'(i), POS_W'(j), rand_value(), CHECK_MODEL, '0);
	endtask

	task automatic run_phase(input logic [REG_W-1:0] rows, input logic [REG_W-1:0] inner,
			input logic [REG_W-1:0] cols, input int n_items, input bit squeeze);
		int unsigned n, l, m, computes, r;
		int start;
		logic [POS_W-1:0] row, col;
		settle();
		write_reg(REG_ROWS, rows);
		write_reg(REG_INNER, inner);
		write_reg(REG_COLS, cols);
		write_reg(REG_SPARE, REG_W'($urandom()));
		n = eff_dim(rows);
		l = eff_dim(inner);
		m = eff_dim(cols);
		if (items_sent < QUIET_FROM) begin
			gap_on   = $urandom_range(0, 3) != 0;
			stall_on = $urandom_range(0, 3) != 0;
		end else begin
			gap_on   = 1'b0;
			stall_on = 1'b0;
		end
		computes = 0;
		if (n*l*m > 256)
			load_missing_operands();
		if (squeeze) begin
			// starve the output side so the block backs up and refuses words
			long_hold_req = 1'b1;
			repeat (24)
				send_item(CMD_RD, POS_W'($urandom()), POS_W'($urandom()), rand_value(),
					CHECK_MODEL, '0);
		end
		start = items_sent;
		while (items_sent - start < n_items) begin
			r   = $urandom_range(0, 99);
			row = POS_W'($urandom());
			col = POS_W'($urandom());
			if (r < 30) begin
				if (n != 0 && l != 0) begin
					row = POS_W'($urandom_range(0, n - 1));
					col = POS_W'($urandom_range(0, l - 1));
				end
				send_item(CMD_WR_A, row, col, rand_value(), CHECK_MODEL, '0);
			end else if (r < 55) begin
				if (l != 0 && m != 0) begin
					row = POS_W'($urandom_range(0, l - 1));
					col = POS_W'($urandom_range(0, m - 1));
				end
				send_item(CMD_WR_B, row, col, rand_value(), CHECK_MODEL, '0);
			end else if (r < 62) begin
				send_item($urandom_range(0, 1) ? CMD_WR_B : CMD_WR_A, row, col, rand_value(),
					CHECK_MODEL, '0);
			end else if (r < 82) begin
				if (r < 77 && n != 0 && m != 0) begin
					row = POS_W'($urandom_range(0, n - 1));
					col = POS_W'($urandom_range(0, m - 1));
				end
				send_item(CMD_RD, row, col, rand_value(), CHECK_MODEL, '0);
			end else if (r < 92 && (n*l*m <= 256 || computes < 2)) begin
				load_missing_operands();
				send_item($urandom_range(0, 1) ? CMD_MAC : CMD_MUL, row, col, rand_value(),
					CHECK_MODEL, '0);
				computes++;
			end else if (r < 96) begin
				send_item(CMD_CLR, row, col, rand_value(), CHECK_MODEL, '0);
			end else begin
				send_item($urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6, row, col,
					rand_value(), CHECK_MODEL, '0);
			end
		end
	endtask

	// output side: random short stalls, plus one long hold on request
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (stall_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		out_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (words_due.size() == 0) begin
					$error("unexpected word: read_value %h done_res %b", m_tdata, m_tuser[0]);
					mismatches++;
				end else begin
					want = words_due.pop_front();
					if (m_tdata !== want.read_value) begin
						$error("read_value: expected %h, got %h", want.read_value, m_tdata);
						mismatches++;
					end
					if (m_tuser[0] !== want.done_res) begin
						$error("done_res: expected %b, got %b", want.done_res, m_tuser[0]);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		int k;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		gap_on        = 1'b0;
		stall_on      = 1'b0;
		long_hold_req = 1'b0;
		mismatches    = 0;
		items_sent    = 0;
		dim_rows      = DIM_RESET;
		dim_inner     = DIM_RESET;
		dim_cols      = DIM_RESET;
		for (k = 0; k < DIM*DIM; k++) begin
			a_mem[k]    = '0;
			b_mem[k]    = '0;
			c_mem[k]    = '0;
			a_loaded[k] = 1'b0;
			b_loaded[k] = 1'b0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_ROWS, 5'd2);
		write_reg(REG_INNER, 5'd2);
		write_reg(REG_COLS, 5'd2);
		gap_on   = 1'b1;
		stall_on = 1'b1;
		for (k = 0; k < DIR_N; k++)
			send_item(dir_tab[k].cmd, dir_tab[k].row, dir_tab[k].col, dir_tab[k].value,
				dir_tab[k].typed, {dir_tab[k].t_value, dir_tab[k].t_done});

		run_phase(5'd1, 5'd1, 5'd1, 60, 1'b0);
		run_phase(5'd0, 5'd3, 5'd2, 40, 1'b0);
		run_phase(5'd3, 5'd0, 5'd2, 40, 1'b0);
		run_phase(5'd2, 5'd3, 5'd0, 40, 1'b1);
		run_phase(5'd31, 5'd2, 5'd2, 50, 1'b0);
		run_phase(5'd2, 5'd17, 5'd2, 50, 1'b0);
		run_phase(5'd2, 5'd2, 5'd24, 50, 1'b0);
		run_phase(5'd16, 5'd16, 5'd16, 40, 1'b0);
		while (items_sent < TARGET_ITEMS)
			run_phase(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4),
				($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5),
				($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4), 80, 1'b0);

		settle();
		repeat (32) @(posedge clk);
		if (mismatches == 0)
			$display("tb_int_matrix_multiply_accumulate passed");
		else
			$display("tb_int_matrix_multiply_accumulate failed");
		$finish;
	end

endmodule
